FILE: rtl/srtf_pkg.sv
// shared types and constants of the srtf scheduler
// no dependencies; used by srtf_ctrl, srtf_dp and the top level
package srtf_pkg;

  // default configuration
  localparam int unsigned MaxProcsDef = 16;
  localparam int unsigned TimeBitsDef = 16;

  // fixed payload widths
  localparam int unsigned IdW    = 8;
  localparam int unsigned FieldW = 16;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;        // write a new table entry (dropped when full)
    logic tick_start;  // start of a tick, clear the search
    logic scan_rd;     // read the entry at the scan pointer
    logic commit;      // retire the tick, fill the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;       // no entry loaded
    logic scan_last;   // scan pointer at the last loaded entry
    logic out_free;    // result register can take a result
  } stat_t;

endpackage

FILE: rtl/srtf_if.sv
// item channels of the srtf scheduler: load/tick requests and tick results
// depends on nothing
interface srtf_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  process_id;
  logic [15:0] arrival_time;
  logic [15:0] burst_time;

  modport source (output valid, operation, process_id, arrival_time, burst_time,
                  input ready);
  modport sink   (input valid, operation, process_id, arrival_time, burst_time,
                  output ready);
endinterface

interface srtf_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] time_now;
  logic        idle;
  logic [7:0]  running_id;
  logic        switched;
  logic        finished;
  logic [15:0] waiting_time;
  logic        all_done;

  modport source (output valid, time_now, idle, running_id, switched, finished,
                  waiting_time, all_done, input ready);
  modport sink   (input valid, time_now, idle, running_id, switched, finished,
                  waiting_time, all_done, output ready);
endinterface

FILE: rtl/srtf_ram.sv
// generic single write port ram with registered read
// no dependencies
module srtf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/srtf_ctrl.sv
// controller of the srtf scheduler: sequences load, scan and commit
// depends on srtf_pkg
module srtf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_op_i,
  output logic                in_ready_o,
  input  srtf_pkg::stat_t     stat_i,
  output srtf_pkg::cmd_t      cmd_o
);
  import srtf_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (op_e'(in_op_i) == OP_TICK) begin
            cmd_o.tick_start = 1'b1;
            state_d = stat_i.empty ? ST_UPDATE : ST_SCAN;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/srtf_dp.sv
// datapath of the srtf scheduler: process table, min search, time and result register
// depends on srtf_pkg and srtf_ram
module srtf_dp #(
  parameter int unsigned MaxProcs = srtf_pkg::MaxProcsDef,
  parameter int unsigned TimeBits = srtf_pkg::TimeBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  srtf_pkg::cmd_t              cmd_i,
  output srtf_pkg::stat_t             stat_o,
  input  logic [srtf_pkg::IdW-1:0]    process_id_i,
  input  logic [srtf_pkg::FieldW-1:0] arrival_time_i,
  input  logic [srtf_pkg::FieldW-1:0] burst_time_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [srtf_pkg::FieldW-1:0] time_now_o,
  output logic                        idle_o,
  output logic [srtf_pkg::IdW-1:0]    running_id_o,
  output logic                        switched_o,
  output logic                        finished_o,
  output logic [srtf_pkg::FieldW-1:0] waiting_time_o,
  output logic                        all_done_o
);
  import srtf_pkg::*;

  localparam int unsigned IdxW  = $clog2(MaxProcs);
  localparam int unsigned CntW  = $clog2(MaxProcs + 1);
  localparam int unsigned WordW = IdW + TimeBits + 2 * FieldW;
  localparam int unsigned CalcW = ((TimeBits > FieldW) ? TimeBits : FieldW) + 2;

  // table word: {id, arrival, burst, remaining}
  logic               we;
  logic [IdxW-1:0]    waddr;
  logic [WordW-1:0]   wdata, rdata;
  logic [IdW-1:0]     rd_id;
  logic [TimeBits-1:0] rd_arr;
  logic [FieldW-1:0]  rd_burst, rd_rem;

  logic [CntW-1:0]     loaded_q, finished_q, finished_d;
  logic [TimeBits-1:0] time_q;
  logic [IdxW-1:0]     prev_q;
  logic                first_q;
  logic [IdxW-1:0]     scan_q, cmp_idx_q;
  logic                cmp_v_q;

  logic                found_q;
  logic [IdxW-1:0]     best_idx_q;
  logic [IdW-1:0]      best_id_q;
  logic [TimeBits-1:0] best_arr_q;
  logic [FieldW-1:0]   best_burst_q, best_rem_q;

  logic                full, take;
  logic [FieldW-1:0]   ld_burst;
  logic [TimeBits-1:0] ld_arr;
  logic [TimeBits+FieldW-1:0] arr_ext, now_ext;
  logic                fin;
  logic [CalcW-1:0]    wait_calc;
  logic [TimeBits-1:0] wait_val;
  logic [TimeBits+FieldW-1:0] wait_ext;

  srtf_ram #(
    .Width (WordW),
    .Depth (MaxProcs)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (scan_q),
    .rdata_o (rdata)
  );

  assign {rd_id, rd_arr, rd_burst, rd_rem} = rdata;

  // load path: arrival modulo the time range, zero burst taken as one
  assign full     = (loaded_q >= CntW'(MaxProcs));
  assign arr_ext  = {{TimeBits{1'b0}}, arrival_time_i};
  assign ld_arr   = arr_ext[TimeBits-1:0];
  assign ld_burst = (burst_time_i == '0) ? FieldW'(1) : burst_time_i;

  assign fin = found_q && (best_rem_q == FieldW'(1));

  always_comb begin
    we    = 1'b0;
    waddr = loaded_q[IdxW-1:0];
    wdata = {process_id_i, ld_arr, ld_burst, ld_burst};
    if (cmd_i.load && !full) begin
      we = 1'b1;
    end else if (cmd_i.commit && found_q) begin
      we    = 1'b1;
      waddr = best_idx_q;
      wdata = {best_id_q, best_arr_q, best_burst_q, best_rem_q - FieldW'(1)};
    end
  end

  // eligible entry beats the best so far on strictly smaller remaining time
  assign take = cmp_v_q && (rd_arr <= time_q) && (rd_rem != '0)
                && (!found_q || (rd_rem < best_rem_q));

  // waiting time: now - arrival - burst + 1, never above now, clamped at zero
  assign wait_calc = CalcW'(time_q) + CalcW'(1) - CalcW'(best_arr_q) - CalcW'(best_burst_q);
  assign wait_val  = wait_calc[CalcW-1] ? '0 : wait_calc[TimeBits-1:0];
  assign wait_ext  = {{FieldW{1'b0}}, wait_val};
  assign now_ext   = {{FieldW{1'b0}}, time_q};

  assign finished_d = finished_q + CntW'(fin);

  assign stat_o.empty     = (loaded_q == '0);
  assign stat_o.scan_last = (CntW'(scan_q) == loaded_q - CntW'(1));
  assign stat_o.out_free  = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= '0;
      finished_q  <= '0;
      time_q      <= '0;
      prev_q      <= '0;
      first_q     <= 1'b1;
      scan_q      <= '0;
      cmp_v_q     <= 1'b0;
      found_q     <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      cmp_v_q <= cmd_i.scan_rd;
      if (cmd_i.load && !full) begin
        loaded_q <= loaded_q + CntW'(1);
        if (loaded_q == '0) begin
          time_q <= ld_arr;
        end
      end
      if (cmd_i.tick_start) begin
        scan_q  <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.scan_rd) begin
        scan_q <= scan_q + IdxW'(1);
      end
      if (take) begin
        found_q <= 1'b1;
      end
      if (out_valid_o && out_ready_i && !cmd_i.commit) begin
        out_valid_o <= 1'b0;
      end
      if (cmd_i.commit) begin
        out_valid_o <= 1'b1;
        finished_q  <= finished_d;
        if (time_q != '1) begin
          time_q <= time_q + TimeBits'(1);
        end
        if (found_q) begin
          first_q <= 1'b0;
          prev_q  <= best_idx_q;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= scan_q;
    if (take) begin
      best_idx_q   <= cmp_idx_q;
      best_id_q    <= rd_id;
      best_arr_q   <= rd_arr;
      best_burst_q <= rd_burst;
      best_rem_q   <= rd_rem;
    end
    if (cmd_i.commit) begin
      time_now_o     <= now_ext[FieldW-1:0];
      idle_o         <= !found_q;
      running_id_o   <= found_q ? best_id_q : '0;
      switched_o     <= found_q && (first_q || (prev_q != best_idx_q));
      finished_o     <= fin;
      waiting_time_o <= fin ? wait_ext[FieldW-1:0] : '0;
      all_done_o     <= (finished_d == loaded_q);
    end
  end

endmodule

FILE: rtl/srtf_preemptive_scheduler.sv
// top level of the preemptive shortest-remaining-time-first scheduler
// depends on srtf_pkg, srtf_if, srtf_ram, srtf_ctrl and srtf_dp
//
// A load item (operation 0) appends a process (id, arrival, burst) to a table
// of MaxProcs entries; loads into a full table are dropped and a zero burst
// counts as one. The first load sets the clock to its arrival. A tick item
// (operation 1) searches for the least remaining time: the table sits in one
// ram with a single read port, so the search walks the entries one per cycle,
// then a drain state settles the last compare and an update state commits the
// result; with an empty table the tick goes straight to the update state.
// Ties go to the earliest loaded entry. Every tick gives exactly one result;
// loads give none. The result register frees the input side, so the next item
// is taken while a result still waits; a tick stalls in its commit cycle only
// while the previous result is still unread. Time saturates at 2^TimeBits - 1.
module srtf_preemptive_scheduler #(
  parameter int unsigned MaxProcs = srtf_pkg::MaxProcsDef,
  parameter int unsigned TimeBits = srtf_pkg::TimeBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  srtf_req_if.sink   req_i,
  srtf_rsp_if.source rsp_o
);
  import srtf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // control sequencing
  srtf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_op_i    (req_i.operation),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // table, search and result register
  srtf_dp #(
    .MaxProcs (MaxProcs),
    .TimeBits (TimeBits)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .process_id_i   (req_i.process_id),
    .arrival_time_i (req_i.arrival_time),
    .burst_time_i   (req_i.burst_time),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .time_now_o     (rsp_o.time_now),
    .idle_o         (rsp_o.idle),
    .running_id_o   (rsp_o.running_id),
    .switched_o     (rsp_o.switched),
    .finished_o     (rsp_o.finished),
    .waiting_time_o (rsp_o.waiting_time),
    .all_done_o     (rsp_o.all_done)
  );

  // at most one datapath command per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.tick_start, cmd.scan_rd, cmd.commit}))
    else $error("more than one datapath command in a cycle");

  // an idle tick serves nobody
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.idle) |->
      (!rsp_o.finished && !rsp_o.switched && (rsp_o.running_id == '0)
       && (rsp_o.waiting_time == '0)))
    else $error("idle result carries service fields");

  // a tick keeps the input closed while it runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && (op_e'(req_i.operation) == OP_TICK))
      |=> !req_i.ready)
    else $error("input open during a tick");

  // a result is only written in a commit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(cmd.commit))
    else $error("result valid without a commit");

endmodule
